// File: src/sbec_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the scored budget evicting cache.
// No dependencies.
package sbec_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 48;

    localparam int FUNC_W     = 3;
    localparam int KEY_W      = 48;
    localparam int HANDLE_W   = 32;
    localparam int BYTES_W    = 32;
    localparam int PRIO_W     = 16;
    localparam int TICK_W     = 32;
    localparam int RES_W      = 36;
    localparam int WEIGHT_W   = 16;
    localparam int LIMIT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 36;
    localparam int PEN_W      = WEIGHT_W + TICK_W;
    localparam int SCORE_W    = PEN_W + 2;
    localparam int MAX_EVICT  = 16;
    localparam int EVC_W      = $clog2(MAX_EVICT + 1);
    localparam int EVQ_IW     = $clog2(MAX_EVICT);

    localparam logic [FUNC_W-1:0] FN_PUT     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_TOUCH   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_PROTECT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_EVICT   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_TICK    = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd2;

    localparam logic [RES_W-1:0]    BUDGET_RST = 36'd268435456;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 5'd16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEL,
        ST_EXEC,
        ST_FIN,
        ST_OUT,
        ST_EV_CHK,
        ST_SCAN,
        ST_DRAIN,
        ST_REMOVE,
        ST_EV_END,
        ST_EV_RD,
        ST_EV_LD
    } fsm_state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_LOOK,
        CMD_SEL,
        CMD_EXEC,
        CMD_FIN,
        CMD_SCAN_START,
        CMD_SCAN,
        CMD_REMOVE,
        CMD_EV_NULL,
        CMD_EV_RD,
        CMD_EV_LD,
        CMD_POP
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_evict;
        logic over;
        logic evict_cap;
        logic best_found;
        logic n_zero;
        logic scan_last;
        logic out_last;
    } dp_stat_t;

endpackage

// File: src/sbec_if.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the cache.
// Depends on sbec_pkg.
interface sbec_req_if
    import sbec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [KEY_W-1:0]    tile_key;
    logic [HANDLE_W-1:0] tile_handle;
    logic [BYTES_W-1:0]  tile_bytes;
    logic signed [PRIO_W-1:0] priority_req;
    logic                protect_flag;

    modport source (output valid, func, tile_key, tile_handle, tile_bytes,
                    priority_req, protect_flag, input ready);
    modport sink (input valid, func, tile_key, tile_handle, tile_bytes,
                  priority_req, protect_flag, output ready);
endinterface

interface sbec_rsp_if
    import sbec_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    out_key;
    logic [HANDLE_W-1:0] out_handle;
    logic                hit;
    logic                evicted;
    logic [STATUS_W-1:0] status;
    logic                over_budget;
    logic [RES_W-1:0]    bytes_used;
    logic                last;

    modport source (output valid, out_key, out_handle, hit, evicted, status,
                    over_budget, bytes_used, last, input ready);
    modport sink (input valid, out_key, out_handle, hit, evicted, status,
                  over_budget, bytes_used, last, output ready);
endinterface

// File: src/sbec_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the cache: steps the datapath through lookup, update and evict scans.
// Depends on sbec_pkg.
module sbec_ctrl
    import sbec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    fsm_state_t state_reg, state_next;
    logic       drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = stat.in_is_evict ? ST_EV_CHK : ST_LOOK;
            end
            ST_LOOK:   state_next = ST_SEL;
            ST_SEL:    state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_FIN;
            ST_FIN:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                    state_next = stat.out_last ? ST_IDLE : ST_EV_RD;
            end
            ST_EV_CHK:
            begin
                state_next = (stat.over && !stat.evict_cap) ? ST_SCAN : ST_EV_END;
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                drain_next = !drain_reg;
                if (drain_reg)
                    state_next = ST_REMOVE;
            end
            ST_REMOVE: state_next = stat.best_found ? ST_EV_CHK : ST_EV_END;
            ST_EV_END: state_next = stat.n_zero ? ST_OUT : ST_EV_RD;
            ST_EV_RD:  state_next = ST_EV_LD;
            ST_EV_LD:  state_next = ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        cmd       = CMD_NONE;
        case (state_reg)
            ST_IDLE:   cmd = in_valid ? CMD_CAPTURE : CMD_NONE;
            ST_LOOK:   cmd = CMD_LOOK;
            ST_SEL:    cmd = CMD_SEL;
            ST_EXEC:   cmd = CMD_EXEC;
            ST_FIN:    cmd = CMD_FIN;
            ST_OUT:    cmd = (out_ready && !stat.out_last) ? CMD_POP : CMD_NONE;
            ST_EV_CHK: cmd = (stat.over && !stat.evict_cap) ? CMD_SCAN_START : CMD_NONE;
            ST_SCAN:   cmd = CMD_SCAN;
            ST_REMOVE: cmd = stat.best_found ? CMD_REMOVE : CMD_NONE;
            ST_EV_END: cmd = stat.n_zero ? CMD_EV_NULL : CMD_NONE;
            ST_EV_RD:  cmd = CMD_EV_RD;
            ST_EV_LD:  cmd = CMD_EV_LD;
            default:   cmd = CMD_NONE;
        endcase
    end

endmodule

// File: src/sbec_dp.sv
`timescale 1ns / 1ps
// Datapath of the cache: slot table, byte and tick counters, score pipeline,
// evict queue, configuration and result registers. Depends on sbec_pkg.
module sbec_dp
    import sbec_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic [FUNC_W-1:0]     func,
    input  logic [KEY_W-1:0]      tile_key,
    input  logic [HANDLE_W-1:0]   tile_handle,
    input  logic [BYTES_W-1:0]    tile_bytes,
    input  logic [PRIO_W-1:0]     priority_req,
    input  logic                  protect_flag,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [KEY_W-1:0]      out_key,
    output logic [HANDLE_W-1:0]   out_handle,
    output logic                  hit,
    output logic                  evicted,
    output logic [STATUS_W-1:0]   status,
    output logic                  over_budget,
    output logic [RES_W-1:0]      bytes_used,
    output logic                  last
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // slot table
    logic                valid_reg  [ENTRIES];
    logic                prot_reg   [ENTRIES];
    logic [KEY_BITS-1:0] skey_reg   [ENTRIES];
    logic [HANDLE_W-1:0] shandle_reg[ENTRIES];
    logic [BYTES_W-1:0]  sbytes_reg [ENTRIES];
    logic [PRIO_W-1:0]   sprio_reg  [ENTRIES];
    logic [TICK_W-1:0]   stick_reg  [ENTRIES];

    logic [RES_W-1:0]    resident_reg;
    logic [TICK_W-1:0]   tick_reg;
    logic [CW-1:0]       count_reg;
    logic [RES_W-1:0]    budget_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    // request
    logic [FUNC_W-1:0]   rq_func_reg;
    logic [KEY_BITS-1:0] rq_key_reg;
    logic [HANDLE_W-1:0] rq_handle_reg;
    logic [BYTES_W-1:0]  rq_bytes_reg;
    logic [PRIO_W-1:0]   rq_prio_reg;
    logic                rq_pflag_reg;

    logic                hit_reg;
    logic [IW-1:0]       hit_idx_reg;
    logic                free_ok_reg;
    logic [IW-1:0]       free_idx_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [HANDLE_W-1:0] res_handle_reg;

    // registered slot read
    logic [KEY_BITS-1:0] rd_key_reg;
    logic [HANDLE_W-1:0] rd_handle_reg;
    logic [BYTES_W-1:0]  rd_bytes_reg;
    logic [PRIO_W-1:0]   rd_prio_reg;
    logic [TICK_W-1:0]   rd_tick_reg;
    logic                rd_elig_reg;
    logic [IW-1:0]       rd_idx_reg;

    // score pipeline
    logic                s1_vld_reg;
    logic                s2_vld_reg;
    logic [PEN_W-1:0]    s2_pen_reg;
    logic [PRIO_W-1:0]   s2_prio_reg;
    logic                s2_elig_reg;
    logic [IW-1:0]       s2_idx_reg;
    logic [BYTES_W-1:0]  s2_bytes_reg;
    logic                best_found_reg;
    logic [IW-1:0]       best_idx_reg;
    logic signed [SCORE_W-1:0] best_score_reg;
    logic [BYTES_W-1:0]  best_bytes_reg;

    logic [IW-1:0]       scan_idx_reg;
    logic [IW-1:0]       evq_reg [MAX_EVICT];
    logic [EVC_W-1:0]    n_reg;
    logic [EVC_W-1:0]    k_reg;

    // result
    logic [KEY_W-1:0]    o_key_reg;
    logic [HANDLE_W-1:0] o_handle_reg;
    logic                o_hit_reg;
    logic                o_ev_reg;
    logic [STATUS_W-1:0] o_status_reg;
    logic                o_over_reg;
    logic [RES_W-1:0]    o_bytes_reg;
    logic                o_last_reg;

    logic [KEY_BITS-1:0] in_key;
    logic [KEY_W-1:0]    rq_key_out;
    logic [KEY_W-1:0]    rd_key_out;
    logic [ENTRIES-1:0]  match;
    logic                any_hit;
    logic [IW-1:0]       hit_idx;
    logic                any_free;
    logic [IW-1:0]       free_idx;
    logic [IW-1:0]       tgt;
    logic [IW-1:0]       rd_idx;
    logic                over;
    logic                do_put;
    logic [BYTES_W-1:0]  old_bytes;
    logic [RES_W-1:0]    put_res;
    logic [TICK_W-1:0]   age;
    logic signed [SCORE_W-1:0] score;
    logic                take_best;

    always_comb
    begin
        in_key     = '0;
        rq_key_out = '0;
        rd_key_out = '0;
        for (int b = 0; b < KEY_BITS; b++)
        begin
            if (b < KEY_W)
            begin
                in_key[b]     = tile_key[b];
                rq_key_out[b] = rq_key_reg[b];
                rd_key_out[b] = rd_key_reg[b];
            end
        end
    end

    always_comb
    begin
        any_hit  = 1'b0;
        hit_idx  = '0;
        any_free = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (skey_reg[i] == rq_key_reg);
            if (match[i])
            begin
                any_hit = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign tgt = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb
    begin
        case (cmd)
            CMD_SEL:   rd_idx = tgt;
            CMD_SCAN:  rd_idx = scan_idx_reg;
            CMD_EV_RD: rd_idx = evq_reg[k_reg[EVQ_IW-1:0]];
            default:   rd_idx = '0;
        endcase
    end

    assign over = (resident_reg > budget_reg)
                  || (CMPW'(count_reg) > CMPW'(limit_reg));

    assign do_put    = (rq_func_reg == FN_PUT) && (hit_reg || free_ok_reg);
    assign old_bytes = hit_reg ? rd_bytes_reg : '0;
    assign put_res   = resident_reg - RES_W'(old_bytes) + RES_W'(rq_bytes_reg);

    assign age   = tick_reg - rd_tick_reg;
    assign score = $signed({{(SCORE_W - PRIO_W){s2_prio_reg[PRIO_W-1]}}, s2_prio_reg})
                   - $signed({{(SCORE_W - PEN_W){1'b0}}, s2_pen_reg});
    assign take_best = s2_vld_reg && s2_elig_reg
                       && (!best_found_reg || (score < best_score_reg));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                prot_reg[i]  <= 1'b0;
            end
            resident_reg   <= '0;
            tick_reg       <= '0;
            count_reg      <= '0;
            budget_reg     <= BUDGET_RST;
            limit_reg      <= LIMIT_RST;
            weight_reg     <= WEIGHT_RST;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            n_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            s1_vld_reg <= (cmd == CMD_SCAN);
            s2_vld_reg <= s1_vld_reg;
            if (take_best)
                best_found_reg <= 1'b1;
            case (cmd)
                CMD_CAPTURE:
                begin
                    n_reg <= '0;
                    k_reg <= '0;
                end
                CMD_EXEC:
                begin
                    if (do_put)
                    begin
                        resident_reg <= put_res;
                        if (!hit_reg)
                        begin
                            valid_reg[tgt] <= 1'b1;
                            prot_reg[tgt]  <= 1'b0;
                            count_reg      <= count_reg + 1'b1;
                        end
                    end
                    if ((rq_func_reg == FN_PROTECT) && hit_reg)
                        prot_reg[tgt] <= rq_pflag_reg;
                    if (rq_func_reg == FN_TICK)
                        tick_reg <= tick_reg + 1'b1;
                end
                CMD_SCAN_START: best_found_reg <= 1'b0;
                CMD_REMOVE:
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                    prot_reg[best_idx_reg]  <= 1'b0;
                    resident_reg <= resident_reg - RES_W'(best_bytes_reg);
                    count_reg    <= count_reg - 1'b1;
                    n_reg        <= n_reg + 1'b1;
                end
                CMD_POP: k_reg <= k_reg + 1'b1;
                default: ;
            endcase
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_BUDGET: budget_reg <= cfg_data[RES_W-1:0];
                    CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                    CFG_WEIGHT: weight_reg <= cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rd_key_reg    <= skey_reg[rd_idx];
        rd_handle_reg <= shandle_reg[rd_idx];
        rd_bytes_reg  <= sbytes_reg[rd_idx];
        rd_prio_reg   <= sprio_reg[rd_idx];
        rd_tick_reg   <= stick_reg[rd_idx];
        rd_elig_reg   <= valid_reg[rd_idx] && !prot_reg[rd_idx];
        rd_idx_reg    <= rd_idx;

        s2_pen_reg   <= PEN_W'(weight_reg) * PEN_W'(age);
        s2_prio_reg  <= rd_prio_reg;
        s2_elig_reg  <= rd_elig_reg;
        s2_idx_reg   <= rd_idx_reg;
        s2_bytes_reg <= rd_bytes_reg;

        if (take_best)
        begin
            best_idx_reg   <= s2_idx_reg;
            best_score_reg <= score;
            best_bytes_reg <= s2_bytes_reg;
        end

        case (cmd)
            CMD_CAPTURE:
            begin
                rq_func_reg   <= func;
                rq_key_reg    <= in_key;
                rq_handle_reg <= tile_handle;
                rq_bytes_reg  <= tile_bytes;
                rq_prio_reg   <= priority_req;
                rq_pflag_reg  <= protect_flag;
            end
            CMD_LOOK:
            begin
                hit_reg      <= any_hit;
                hit_idx_reg  <= hit_idx;
                free_ok_reg  <= any_free;
                free_idx_reg <= free_idx;
            end
            CMD_EXEC:
            begin
                if (do_put)
                begin
                    skey_reg[tgt]    <= rq_key_reg;
                    shandle_reg[tgt] <= rq_handle_reg;
                    sbytes_reg[tgt]  <= rq_bytes_reg;
                    sprio_reg[tgt]   <= rq_prio_reg;
                    stick_reg[tgt]   <= tick_reg;
                end
                case (rq_func_reg)
                    FN_PUT:
                    begin
                        res_handle_reg <= '0;
                        res_status_reg <= (hit_reg || free_ok_reg) ? STAT_OK : STAT_FULL;
                    end
                    FN_TOUCH:
                    begin
                        res_handle_reg <= '0;
                        if (hit_reg)
                        begin
                            sprio_reg[tgt] <= rq_prio_reg;
                            stick_reg[tgt] <= tick_reg;
                            res_status_reg <= STAT_OK;
                        end
                        else
                            res_status_reg <= STAT_MISS;
                    end
                    FN_LOOKUP:
                    begin
                        res_handle_reg <= hit_reg ? rd_handle_reg : '0;
                        res_status_reg <= hit_reg ? STAT_OK : STAT_MISS;
                    end
                    FN_PROTECT:
                    begin
                        res_handle_reg <= '0;
                        res_status_reg <= hit_reg ? STAT_OK : STAT_MISS;
                    end
                    default:
                    begin
                        res_handle_reg <= '0;
                        res_status_reg <= STAT_OK;
                    end
                endcase
            end
            CMD_SCAN_START: scan_idx_reg <= '0;
            CMD_SCAN:       scan_idx_reg <= scan_idx_reg + 1'b1;
            CMD_REMOVE:     evq_reg[n_reg[EVQ_IW-1:0]] <= best_idx_reg;
            CMD_FIN:
            begin
                o_key_reg    <= rq_key_out;
                o_handle_reg <= res_handle_reg;
                o_hit_reg    <= hit_reg;
                o_ev_reg     <= 1'b0;
                o_status_reg <= res_status_reg;
                o_over_reg   <= over;
                o_bytes_reg  <= resident_reg;
                o_last_reg   <= 1'b1;
            end
            CMD_EV_NULL:
            begin
                o_key_reg    <= '0;
                o_handle_reg <= '0;
                o_hit_reg    <= 1'b0;
                o_ev_reg     <= 1'b0;
                o_status_reg <= STAT_OK;
                o_over_reg   <= over;
                o_bytes_reg  <= resident_reg;
                o_last_reg   <= 1'b1;
            end
            CMD_EV_LD:
            begin
                o_key_reg    <= rd_key_out;
                o_handle_reg <= rd_handle_reg;
                o_hit_reg    <= 1'b0;
                o_ev_reg     <= 1'b1;
                o_status_reg <= STAT_OK;
                o_over_reg   <= over;
                o_bytes_reg  <= resident_reg;
                o_last_reg   <= (k_reg == (n_reg - 1'b1));
            end
            default: ;
        endcase
    end

    assign stat.in_is_evict = (func == FN_EVICT);
    assign stat.over        = over;
    assign stat.evict_cap   = (n_reg == EVC_W'(MAX_EVICT));
    assign stat.best_found  = best_found_reg;
    assign stat.n_zero      = (n_reg == '0);
    assign stat.scan_last   = (scan_idx_reg == IW'(ENTRIES - 1));
    assign stat.out_last    = o_last_reg;

    assign out_key     = o_key_reg;
    assign out_handle  = o_handle_reg;
    assign hit         = o_hit_reg;
    assign evicted     = o_ev_reg;
    assign status      = o_status_reg;
    assign over_budget = o_over_reg;
    assign bytes_used  = o_bytes_reg;
    assign last        = o_last_reg;

endmodule

// File: src/scored_budget_evicting_cache_unit.sv
`timescale 1ns / 1ps
// Put, touch, lookup, protect, tick: the request passes lookup, select, execute and finish
// states before its result is valid. Evict: each removal runs a budget check, a scan (one
// slot scored per cycle through a 3-stage multiply/compare pipeline), a drain and removal;
// each result then needs a slot read. One request in flight; next accepted after last result.
// Reset clears the slot valid and protect bits, byte total and tick; config takes defaults.
module scored_budget_evicting_cache_unit
    import sbec_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sbec_req_if.sink              req,
    sbec_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sbec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sbec_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (req.func),
        .tile_key     (req.tile_key),
        .tile_handle  (req.tile_handle),
        .tile_bytes   (req.tile_bytes),
        .priority_req (req.priority_req),
        .protect_flag (req.protect_flag),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .out_key      (rsp.out_key),
        .out_handle   (rsp.out_handle),
        .hit          (rsp.hit),
        .evicted      (rsp.evicted),
        .status       (rsp.status),
        .over_budget  (rsp.over_budget),
        .bytes_used   (rsp.bytes_used),
        .last         (rsp.last)
    );

endmodule

// File: src/sbec_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the cache, bound to the top level.
// Depends on sbec_pkg.
module sbec_chk
    import sbec_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [KEY_W-1:0]    rsp_key,
    input logic                rsp_hit,
    input logic                rsp_evicted,
    input logic [STATUS_W-1:0] rsp_status,
    input logic                rsp_last
);

    logic busy_reg, busy_next;

    always_comb
    begin
        busy_next = busy_reg;
        if (req_valid && req_ready)
            busy_next = 1'b1;
        else if (rsp_valid && rsp_ready && rsp_last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |-> !busy_reg)
        else $error("request taken while previous one still open");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> busy_reg)
        else $error("result with no open request");

    a_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_evicted) |-> (!rsp_hit && (rsp_status == STAT_OK)))
        else $error("eviction result with hit or error status");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_key)))
        else $error("stalled result changed");

endmodule

bind scored_budget_evicting_cache_unit sbec_chk u_sbec_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_key     (rsp.out_key),
    .rsp_hit     (rsp.hit),
    .rsp_evicted (rsp.evicted),
    .rsp_status  (rsp.status),
    .rsp_last    (rsp.last)
);
